### rtl/core/usg_pkg.sv
package usg_pkg;
	localparam int MaxCols = 256;
	localparam int MaxRows = 256;
	localparam int CoordW = 8;
	localparam int SideW = 9;
	localparam int AddrW = 16;
	localparam int ColorW = 24;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = 2;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_DETECT = 2'd1;
	localparam logic [1:0] OP_MARK = 2'd2;
	localparam logic [1:0] OP_PAINT = 2'd3;

	localparam logic [9:0] REG_WIDTH = 10'd0;
	localparam logic [9:0] REG_HEIGHT = 10'd1;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic [1:0] op;
		logic in_img;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [SideW-1:0] ex;
		logic [SideW-1:0] ey;
		logic [ColorW-1:0] color;
	} usg_cmd_t;

	typedef struct packed {
		logic found;
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
		logic [SideW-1:0] side;
		logic [ColorW-1:0] color;
	} usg_res_t;
endpackage

### rtl/core/usg_front.sv
module usg_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] op,
	input logic [usg_pkg::CoordW-1:0] x,
	input logic [usg_pkg::CoordW-1:0] y,
	input logic [usg_pkg::SideW-1:0] sd,
	input logic [usg_pkg::ColorW-1:0] color,
	input logic [usg_pkg::SideW-1:0] act_w,
	input logic [usg_pkg::SideW-1:0] act_h,
	output logic q_valid,
	output usg_pkg::usg_cmd_t q_cmd,
	input logic q_pop
);
	import usg_pkg::*;
	usg_cmd_t mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_q, rd_q;
	logic [QueuePtrW:0] cnt_q;
	usg_cmd_t c;
	logic push;
	logic [SideW:0] sx, sy;

	always_comb begin
		sx = {1'b0, x} + {1'b0, sd};
		sy = {1'b0, y} + {1'b0, sd};
		c.op = op;
		c.x = x;
		c.y = y;
		c.in_img = ({1'b0, x} < act_w) && ({1'b0, y} < act_h);
		c.ex = (sx > {1'b0, act_w}) ? act_w : sx[SideW-1:0];
		c.ey = (sy > {1'b0, act_h}) ? act_h : sy[SideW-1:0];
		c.color = color;
		if (op != OP_LOAD && op != OP_DETECT && sd == '0) c.in_img = 1'b0;
	end

	assign in_stall = (cnt_q == (QueuePtrW+1)'(QueueDepth));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(q_pop);
		end
	end
endmodule

### rtl/core/usg_back.sv
module usg_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input usg_pkg::usg_cmd_t q_cmd,
	output logic q_pop,
	input logic [usg_pkg::SideW-1:0] act_w,
	input logic [usg_pkg::SideW-1:0] act_h,
	output logic out_valid,
	input logic out_stall,
	output usg_pkg::usg_res_t res
);
	import usg_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_BASE = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_FILL = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [ColorW-1:0] pix_mem [MaxCols*MaxRows];
	logic ext_mem [MaxCols*MaxRows];
	logic [ColorW-1:0] pix_rd_q;
	logic ext_rd_q;

	logic [2:0] st_q;
	logic [AddrW-1:0] clr_q;
	usg_cmd_t cmd_q;
	logic [SideW-1:0] s_q, i_q;
	logic phase_q; // 0 column, 1 row, then diagonal when i equals s
	logic diag_q; // the diagonal read of this step has been issued
	logic [CoordW-1:0] cx_q, cy_q;
	logic [ColorW-1:0] base_q;
	logic rd_pend_q;
	usg_res_t res_q;
	usg_res_t res_nx_q; // finished result waiting for the output register
	logic ov_q;

	logic [AddrW-1:0] rd_addr, wr_addr;
	logic rd_en, pwr, ewr, ewd;
	logic [SideW:0] gx, gy;
	logic [SideW-1:0] px, py;

	assign out_valid = ov_q;
	assign res = res_q;
	assign q_pop = (st_q == ST_IDLE) && q_valid;

	// Coordinates of the cell checked at the current growth step.
	always_comb begin
		if (i_q == s_q) begin
			px = {1'b0, cmd_q.x} + s_q;
			py = {1'b0, cmd_q.y} + s_q;
		end else if (!phase_q) begin
			px = {1'b0, cmd_q.x} + s_q;
			py = {1'b0, cmd_q.y} + i_q;
		end else begin
			px = {1'b0, cmd_q.x} + i_q;
			py = {1'b0, cmd_q.y} + s_q;
		end
		gx = {1'b0, cmd_q.x} + {1'b0, s_q};
		gy = {1'b0, cmd_q.y} + {1'b0, s_q};
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = {q_cmd.y, q_cmd.x};
		pwr = 1'b0;
		ewr = 1'b0;
		ewd = 1'b1;
		wr_addr = {cy_q, cx_q};
		unique case (st_q)
			ST_CLEAR: begin
				ewr = 1'b1;
				ewd = 1'b0;
				wr_addr = clr_q;
			end
			ST_IDLE: begin
				rd_en = q_valid && q_cmd.op == OP_DETECT;
				if (q_valid && q_cmd.op == OP_LOAD && q_cmd.in_img) begin
					pwr = 1'b1;
					wr_addr = {q_cmd.y, q_cmd.x};
				end
			end
			ST_CHECK: begin
				rd_en = 1'b1;
				rd_addr = {py[CoordW-1:0], px[CoordW-1:0]};
			end
			ST_FILL: begin
				pwr = cmd_q.op == OP_PAINT;
				ewr = cmd_q.op == OP_MARK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pwr) pix_mem[wr_addr] <= (st_q == ST_IDLE) ? q_cmd.color : cmd_q.color;
		if (ewr) ext_mem[wr_addr] <= ewd;
		if (rd_en) begin
			pix_rd_q <= pix_mem[rd_addr];
			ext_rd_q <= ext_mem[rd_addr];
		end
		if (q_pop) cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			ov_q <= 1'b0;
			s_q <= '0;
			i_q <= '0;
			phase_q <= 1'b0;
			diag_q <= 1'b0;
			cx_q <= '0;
			cy_q <= '0;
			base_q <= '0;
			rd_pend_q <= 1'b0;
			res_q <= '0;
			res_nx_q <= '0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						if (q_cmd.op == OP_DETECT) begin
							if (q_cmd.in_img) st_q <= ST_BASE;
							else begin
								res_nx_q <= '0;
								st_q <= ST_OUT;
							end
						end else if (q_cmd.op != OP_LOAD && q_cmd.in_img) begin
							cx_q <= q_cmd.x;
							cy_q <= q_cmd.y;
							st_q <= ST_FILL;
						end
					end
				end
				ST_BASE: begin
					if (ext_rd_q) begin
						res_nx_q <= '0;
						st_q <= ST_OUT;
					end else begin
						base_q <= pix_rd_q;
						s_q <= 9'd1;
						i_q <= '0;
						phase_q <= 1'b0;
						diag_q <= 1'b0;
						rd_pend_q <= 1'b0;
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					// One cell read per cycle; the result of the previous read is judged here.
					if (rd_pend_q && (ext_rd_q || pix_rd_q != base_q)) begin
						res_nx_q <= {1'b1, cmd_q.x, cmd_q.y, s_q, base_q};
						st_q <= ST_OUT;
					end else if (!rd_pend_q && (gx >= {1'b0, act_w} || gy >= {1'b0, act_h})) begin
						res_nx_q <= {1'b1, cmd_q.x, cmd_q.y, s_q, base_q};
						st_q <= ST_OUT;
					end else if (rd_pend_q && diag_q) begin
						// Diagonal passed; grow.
						s_q <= s_q + 1'b1;
						i_q <= '0;
						phase_q <= 1'b0;
						diag_q <= 1'b0;
						rd_pend_q <= 1'b0;
					end else begin
						rd_pend_q <= 1'b1;
						if (i_q == s_q) diag_q <= 1'b1;
						else if (i_q == s_q - 1'b1 && !phase_q) begin
							phase_q <= 1'b1;
							i_q <= '0;
						end else if (i_q == s_q - 1'b1) i_q <= s_q;
						else i_q <= i_q + 1'b1;
					end
				end
				ST_FILL: begin
					if ({1'b0, cx_q} + 9'd1 >= cmd_q.ex) begin
						cx_q <= cmd_q.x;
						cy_q <= cy_q + 1'b1;
						if ({1'b0, cy_q} + 9'd1 >= cmd_q.ey) st_q <= ST_IDLE;
					end else cx_q <= cx_q + 1'b1;
				end
				ST_OUT: begin
					if (!ov_q || !out_stall) begin
						res_q <= res_nx_q;
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/uniform_square_grower_top.sv
// Square grower over a 256 by 256 RGB image with a one-bit extracted map.
// Requests enter a four-word queue and are carried out one at a time by the
// back end, which owns both stores with one read and one write port. Every
// request is taken off the queue in the idle state; a pixel load needs
// nothing more. Mark and paint then visit each clipped cell in turn. A detect
// then judges its start pixel, checks the new column, row and diagonal cells
// for each step that grows the square from side s, stops at the step that
// meets the image edge or a differing or extracted cell, and hands the result
// word to the output register, where it waits while an earlier word is still
// held. After reset the back end clears the extracted map before it takes its
// first word; the input queue still fills during that time and configuration
// writes work.
module uniform_square_grower_top (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] operation,
	input logic [7:0] pos_x,
	input logic [7:0] pos_y,
	input logic [8:0] side_in,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	output logic out_valid,
	input logic out_stall,
	output logic found,
	output logic [7:0] start_col,
	output logic [7:0] start_row,
	output logic [8:0] side,
	output logic [7:0] base_red,
	output logic [7:0] base_green,
	output logic [7:0] base_blue
);
	import usg_pkg::*;
	logic [SideW-1:0] width_q, height_q, act_w, act_h;
	logic q_valid, q_pop;
	usg_cmd_t q_cmd;
	usg_res_t res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			if ({7'd0, paddr} == {REG_WIDTH[7:0], 2'b00}) width_q <= pwdata[SideW-1:0];
			if ({7'd0, paddr} == {REG_HEIGHT[7:0], 2'b00}) height_q <= pwdata[SideW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if ({7'd0, paddr} == {REG_WIDTH[7:0], 2'b00}) prdata = {23'd0, width_q};
		else if ({7'd0, paddr} == {REG_HEIGHT[7:0], 2'b00}) prdata = {23'd0, height_q};
	end

	// Zero acts as one and anything past the grid acts as the grid size.
	assign act_w = (width_q == '0) ? 9'd1 : (width_q > 9'd256) ? 9'd256 : width_q;
	assign act_h = (height_q == '0) ? 9'd1 : (height_q > 9'd256) ? 9'd256 : height_q;

	usg_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.op(operation), .x(pos_x), .y(pos_y), .sd(side_in),
		.color({red, green, blue}), .act_w, .act_h,
		.q_valid, .q_cmd, .q_pop
	);

	usg_back u_back (
		.clk, .arst_n, .q_valid, .q_cmd, .q_pop, .act_w, .act_h,
		.out_valid, .out_stall, .res
	);

	assign found = res.found;
	assign start_col = res.col;
	assign start_row = res.row;
	assign side = res.side;
	assign base_red = res.color[23:16];
	assign base_green = res.color[15:8];
	assign base_blue = res.color[7:0];
endmodule

### rtl/core/usg_checker.sv
module usg_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic found,
	input logic [8:0] side,
	input logic [7:0] start_col
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(side)) else $error("held word changed");
	a_nf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> side == 9'd0 && start_col == 8'd0) else $error("bad miss word");
	a_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> side != 9'd0) else $error("zero side on hit");
endmodule

bind uniform_square_grower_top usg_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .found, .side, .start_col
);
